>>> rtl/sbt_pkg.sv
// Shared types and constants for the sorted best-times table.
`default_nettype none

package sbt_pkg;

  // Field widths
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned ID_W    = 16;
  localparam int unsigned RIDX_W  = 8;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned SEC_W   = 23;
  localparam int unsigned MIN_W   = 17;

  // Largest limit the 4-bit register can express
  localparam int unsigned MAX_LIMIT = (2 ** CNT_W) - 1;

  localparam int unsigned MS_PER_SECOND     = 1000;
  localparam int unsigned MS_PER_MINUTE     = 60000;
  localparam int unsigned MAX_ENTRIES_RESET = 5;

  // Reciprocals: floor(t / 1000) = (t * SEC_RECIP) >> SEC_SHIFT and
  // floor(t / 60000) = (t * MIN_RECIP) >> MIN_SHIFT, exact for any 32-bit t
  localparam logic [TIME_W-1:0] SEC_RECIP = 32'h1062_4DD3;
  localparam int unsigned       SEC_SHIFT = 38;
  localparam logic [TIME_W-1:0] MIN_RECIP = 32'h45E7_B273;
  localparam int unsigned       MIN_SHIFT = 46;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT     = 3'd0,
    KIND_DROP_LONG  = 3'd1,
    KIND_DROP_SHORT = 3'd2,
    KIND_CLEAR      = 3'd3,
    KIND_QUERY      = 3'd4
  } kind_e;

  // Divider status back to the sequencer
  typedef struct packed {
    logic             done;
    logic [SEC_W-1:0] seconds;
    logic [MIN_W-1:0] minutes;
  } div_res_t;

endpackage

`default_nettype wire

>>> rtl/sbt_in_if.sv
// Input item channel: valid/ready handshake with the request fields.
`default_nettype none

interface sbt_in_if;
  logic                         valid;
  logic                         ready;
  logic [sbt_pkg::KIND_W-1:0]   kind;
  logic [sbt_pkg::TIME_W-1:0]   lap_time;
  logic [sbt_pkg::ID_W-1:0]     race_number;
  logic                         auto_number;
  logic [sbt_pkg::RIDX_W-1:0]   read_index;

  modport source (
    output valid, kind, lap_time, race_number, auto_number, read_index,
    input  ready
  );
  modport sink (
    input  valid, kind, lap_time, race_number, auto_number, read_index,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/sbt_out_if.sv
// Result item channel: valid/ready handshake with the table summary fields.
`default_nettype none

interface sbt_out_if;
  logic                         valid;
  logic                         ready;
  logic [sbt_pkg::CNT_W-1:0]    entry_total;
  logic [sbt_pkg::TIME_W-1:0]   best_ms;
  logic [sbt_pkg::SEC_W-1:0]    best_seconds;
  logic [sbt_pkg::MIN_W-1:0]    best_minutes;
  logic [sbt_pkg::TIME_W-1:0]   indexed_ms;
  logic [sbt_pkg::ID_W-1:0]     top_race;
  logic [sbt_pkg::TIME_W-1:0]   top_race_ms;

  modport source (
    output valid, entry_total, best_ms, best_seconds, best_minutes,
           indexed_ms, top_race, top_race_ms,
    input  ready
  );
  modport sink (
    input  valid, entry_total, best_ms, best_seconds, best_minutes,
           indexed_ms, top_race, top_race_ms,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/sbt_div.sv
// Divider of one time by 1000 and by 60000 on one shared reciprocal multiplier.
`default_nettype none

module sbt_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [sbt_pkg::TIME_W-1:0] dividend_i,
  output sbt_pkg::div_res_t          res_o
);
  import sbt_pkg::*;

  localparam int unsigned PROD_W = 2 * TIME_W;

  logic                busy_q;
  logic                phase_q;
  logic                done_q;
  logic [TIME_W-1:0]   op_q;
  logic [SEC_W-1:0]    qsec_q;
  logic [MIN_W-1:0]    qmin_q;

  logic [TIME_W-1:0]   recip;
  logic [PROD_W-1:0]   prod;

  // First pass takes the seconds reciprocal, second pass the minutes one
  assign recip = phase_q ? MIN_RECIP : SEC_RECIP;
  assign prod  = PROD_W'(op_q) * PROD_W'(recip);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        phase_q <= 1'b0;
      end else if (busy_q) begin
        phase_q <= 1'b1;
        if (phase_q) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      op_q <= dividend_i;
    end else if (busy_q) begin
      if (phase_q) begin
        qmin_q <= prod[MIN_SHIFT +: MIN_W];
      end else begin
        qsec_q <= prod[SEC_SHIFT +: SEC_W];
      end
    end
  end

  assign res_o.done    = done_q;
  assign res_o.seconds = qsec_q;
  assign res_o.minutes = qmin_q;

endmodule

`default_nettype wire

>>> rtl/sorted_best_times_table_core.sv
// Top level of the sorted best-times table: storage, sequencer and result register.
`default_nettype none

// Keeps up to min(max_entries, CAPACITY, 15) lap times with their race ids,
// ascending by time, in a small register file with one read and one write
// port. Each input item is handled by a sequencer that walks the table one
// entry per cycle. Its steps are: accept the item, trim to the limit, walk
// for the largest id when auto numbering, walk to insert (or to drop the
// shortest), walk for the summary, divide the best time by 1000 and 60000
// with two passes through one reciprocal multiplier, and load the result
// register. Input ready is high only while the sequencer is idle. The
// result register lets the next item start while a result still waits; the
// sequencer stalls at its last step until that result is taken. max_entries
// is written on cfg_we_i and resets to 5; a lowered limit trims the longest
// times at the start of the next item.
module sorted_best_times_table_core #(
  parameter int unsigned CAPACITY = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [sbt_pkg::CNT_W-1:0] cfg_wdata_i,
  sbt_in_if.sink                    item_i,
  sbt_out_if.source                 result_o
);
  import sbt_pkg::*;

  // Count is 4 bits wide, so never more than 15 entries are usable
  localparam int unsigned DEPTH = (CAPACITY < MAX_LIMIT) ? CAPACITY : MAX_LIMIT;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_TRIM   = 8'b0000_0010,
    ST_MAXID  = 8'b0000_0100,
    ST_INSERT = 8'b0000_1000,
    ST_SHIFT  = 8'b0001_0000,
    ST_SCAN   = 8'b0010_0000,
    ST_DIV    = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_e;

  // Table storage
  logic [TIME_W-1:0] times_q [DEPTH];
  logic [ID_W-1:0]   ids_q   [DEPTH];

  // Sequencer state
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  max_q;
  logic [CNT_W-1:0]  idx_q, idx_d;

  // Latched request
  logic [KIND_W-1:0] kind_q;
  logic [TIME_W-1:0] lap_q;
  logic [ID_W-1:0]   race_q;
  logic              auto_q;
  logic [RIDX_W-1:0] ridx_q;

  // Walk accumulators
  logic [ID_W-1:0]   newid_q, newid_d;
  logic [ID_W-1:0]   topid_q, topid_d;
  logic [TIME_W-1:0] topms_q, topms_d;
  logic [TIME_W-1:0] best_q, best_d;
  logic [TIME_W-1:0] idxms_q, idxms_d;

  // Result register
  logic              out_valid_q;
  logic [CNT_W-1:0]  out_total_q;
  logic [TIME_W-1:0] out_best_q;
  logic [SEC_W-1:0]  out_sec_q;
  logic [MIN_W-1:0]  out_min_q;
  logic [TIME_W-1:0] out_idxms_q;
  logic [ID_W-1:0]   out_top_q;
  logic [TIME_W-1:0] out_topms_q;

  // Single read and write port
  logic [CNT_W-1:0]  rd_idx;
  logic [TIME_W-1:0] rd_time;
  logic [ID_W-1:0]   rd_id;
  logic              wr_en;
  logic [CNT_W-1:0]  wr_idx;
  logic [TIME_W-1:0] wr_time;
  logic [ID_W-1:0]   wr_id;

  logic [CNT_W-1:0]  lim;
  logic [CNT_W-1:0]  cnt_trim;
  logic              accept;
  logic              div_start;
  logic              load_out;
  div_res_t          div_res;

  assign item_i.ready = (state_q == ST_IDLE);
  assign accept       = item_i.valid && item_i.ready;

  // Limit in force saturates at the storage depth
  assign lim      = (max_q < CNT_W'(DEPTH)) ? max_q : CNT_W'(DEPTH);
  assign cnt_trim = (cnt_q > lim) ? lim : cnt_q;

  // Reads are only used for indexes below the count, so always in range
  assign rd_time = times_q[rd_idx[IDX_W-1:0]];
  assign rd_id   = ids_q[rd_idx[IDX_W-1:0]];

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    newid_d   = newid_q;
    topid_d   = topid_q;
    topms_d   = topms_q;
    best_d    = best_q;
    idxms_d   = idxms_q;
    rd_idx    = idx_q;
    wr_en     = 1'b0;
    wr_idx    = idx_q;
    wr_time   = lap_q;
    wr_id     = newid_q;
    div_start = 1'b0;
    load_out  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_TRIM;
        end
      end

      ST_TRIM: begin
        cnt_d   = cnt_trim;
        idx_d   = '0;
        topid_d = '0;
        topms_d = '0;
        best_d  = '0;
        idxms_d = '0;
        state_d = ST_SCAN;
        unique case (kind_q)
          KIND_INSERT: begin
            if (auto_q) begin
              newid_d = '0;
              state_d = ST_MAXID;
            end else begin
              newid_d = race_q;
              idx_d   = cnt_trim;
              state_d = ST_INSERT;
            end
          end
          KIND_DROP_LONG: begin
            if (cnt_trim != '0) begin
              cnt_d = cnt_trim - CNT_W'(1);
            end
          end
          KIND_DROP_SHORT: begin
            if (cnt_trim != '0) begin
              idx_d   = CNT_W'(1);
              state_d = ST_SHIFT;
            end
          end
          KIND_CLEAR: begin
            cnt_d = '0;
          end
          default: begin
            // query only, and the unused kinds
          end
        endcase
      end

      // Largest stored id; the new id is one above it, wrapping
      ST_MAXID: begin
        if (idx_q < cnt_q) begin
          if (rd_id > newid_q) begin
            newid_d = rd_id;
          end
          idx_d = idx_q + CNT_W'(1);
        end else begin
          newid_d = newid_q + ID_W'(1);
          idx_d   = cnt_q;
          state_d = ST_INSERT;
        end
      end

      // Walk down from the top, moving up every time >= the new one.
      // Slots at or above the limit are not written: that is the drop.
      ST_INSERT: begin
        rd_idx = idx_q - CNT_W'(1);
        wr_en  = (idx_q < lim);
        if ((idx_q != '0) && (rd_time >= lap_q)) begin
          wr_time = rd_time;
          wr_id   = rd_id;
          idx_d   = idx_q - CNT_W'(1);
        end else begin
          cnt_d   = (cnt_q < lim) ? cnt_q + CNT_W'(1) : lim;
          idx_d   = '0;
          state_d = ST_SCAN;
        end
      end

      // Drop shortest: move every entry down by one
      ST_SHIFT: begin
        if (idx_q < cnt_q) begin
          wr_en   = 1'b1;
          wr_idx  = idx_q - CNT_W'(1);
          wr_time = rd_time;
          wr_id   = rd_id;
          idx_d   = idx_q + CNT_W'(1);
        end else begin
          cnt_d   = cnt_q - CNT_W'(1);
          idx_d   = '0;
          state_d = ST_SCAN;
        end
      end

      // Summary walk: best time, indexed time, first entry with top id
      ST_SCAN: begin
        if (idx_q < cnt_q) begin
          if (idx_q == '0) begin
            best_d  = rd_time;
            topid_d = rd_id;
            topms_d = rd_time;
          end else if (rd_id > topid_q) begin
            topid_d = rd_id;
            topms_d = rd_time;
          end
          if (ridx_q == {{(RIDX_W-CNT_W){1'b0}}, idx_q}) begin
            idxms_d = rd_time;
          end
          idx_d = idx_q + CNT_W'(1);
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end

      ST_DIV: begin
        if (div_res.done) begin
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_q || result_o.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      max_q       <= CNT_W'(MAX_ENTRIES_RESET);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= item_i.kind;
      lap_q  <= item_i.lap_time;
      race_q <= item_i.race_number;
      auto_q <= item_i.auto_number;
      ridx_q <= item_i.read_index;
    end
    newid_q <= newid_d;
    topid_q <= topid_d;
    topms_q <= topms_d;
    best_q  <= best_d;
    idxms_q <= idxms_d;
    if (load_out) begin
      out_total_q <= cnt_q;
      out_best_q  <= best_q;
      out_sec_q   <= div_res.seconds;
      out_min_q   <= div_res.minutes;
      out_idxms_q <= idxms_q;
      out_top_q   <= topid_q;
      out_topms_q <= topms_q;
    end
  end

  // Table write port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      times_q[wr_idx[IDX_W-1:0]] <= wr_time;
      ids_q[wr_idx[IDX_W-1:0]]   <= wr_id;
    end
  end

  sbt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (best_q),
    .res_o      (div_res)
  );

  assign result_o.valid        = out_valid_q;
  assign result_o.entry_total  = out_total_q;
  assign result_o.best_ms      = out_best_q;
  assign result_o.best_seconds = out_sec_q;
  assign result_o.best_minutes = out_min_q;
  assign result_o.indexed_ms   = out_idxms_q;
  assign result_o.top_race     = out_top_q;
  assign result_o.top_race_ms  = out_topms_q;

endmodule

`default_nettype wire

>>> tb/sv/sorted_best_times_table_core_tb.sv
// Self-checking testbench for the sorted best-times table core.
module sorted_best_times_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sbt_pkg::*;

  localparam int unsigned CAPACITY      = 8;
  // Idle cycles before a register write once the table has drained.
  localparam int unsigned SETTLE_CYCLES = 120;
  // Cycles without any item moving on either channel before giving up.
  localparam int unsigned WATCHDOG_MAX  = 4000;
  localparam int unsigned RANDOM_PER_PHASE = 80;

  // One request as driven on the input channel. kind stays a plain vector
  // so the unused codes 5..7 can be sent too.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TIME_W-1:0] lap_time;
    logic [ID_W-1:0]   race_number;
    logic              auto_number;
    logic [RIDX_W-1:0] read_index;
  } lap_item_t;

  // Table summary returned for every item.
  typedef struct packed {
    logic [CNT_W-1:0]  entry_total;
    logic [TIME_W-1:0] best_ms;
    logic [SEC_W-1:0]  best_seconds;
    logic [MIN_W-1:0]  best_minutes;
    logic [TIME_W-1:0] indexed_ms;
    logic [ID_W-1:0]   top_race;
    logic [TIME_W-1:0] top_race_ms;
  } summary_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  sbt_in_if  item_if ();
  sbt_out_if result_if ();

  sorted_best_times_table_core #(
    .CAPACITY (CAPACITY)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .item_i      (item_if),
    .result_o    (result_if)
  );

  // Shadow of the table: one spare slot so an insert into a full table can
  // land before the longest time is dropped again.
  logic [TIME_W-1:0] lap_times [0:CAPACITY];
  logic [ID_W-1:0]   lap_ids   [0:CAPACITY];
  int unsigned       lap_count;
  logic [CNT_W-1:0]  limit_reg;

  lap_item_t pending_items [$];
  summary_t  expected_summaries [$];

  // Handshake flags, sampled at the rising edge; the sender uses item_taken
  // at the following falling edge.
  bit          item_taken;
  bit          result_taken;
  int unsigned idle_cycles;
  int unsigned mismatch_count;

  // Idling knobs, switched per phase so some stretches run flat out.
  bit send_gaps_on;
  bit sink_stalls_on;
  int unsigned burst_left;
  int unsigned send_gap;
  int unsigned stall_left;

  lap_item_t next_item;
  summary_t  want;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Applies one item to the shadow table and returns the summary that the
  // block must report afterwards.
  function automatic summary_t update_table(lap_item_t it);
    summary_t    s;
    int unsigned lim;
    int unsigned pos;
    int unsigned i;
    logic [ID_W-1:0] new_id;
    logic [ID_W-1:0] top;

    lim = (limit_reg < CAPACITY) ? limit_reg : CAPACITY;
    // A limit lowered since the last item trims the longest times first.
    if (lap_count > lim) lap_count = lim;

    case (it.kind)
      KIND_INSERT: begin
        new_id = it.race_number;
        if (it.auto_number) begin
          top = '0;
          for (i = 0; i < lap_count; i++)
            if (lap_ids[i] > top) top = lap_ids[i];
          new_id = top + 1'b1;  // wraps at 16 bits; 1 on an empty table
        end
        // New time goes ahead of any equal stored time.
        pos = 0;
        while (pos < lap_count && lap_times[pos] < it.lap_time) pos++;
        for (i = lap_count; i > pos; i--) begin
          lap_times[i] = lap_times[i-1];
          lap_ids[i]   = lap_ids[i-1];
        end
        lap_times[pos] = it.lap_time;
        lap_ids[pos]   = new_id;
        lap_count++;
        if (lap_count > lim) lap_count--;  // zero limit drops it at once
      end
      KIND_DROP_LONG: begin
        if (lap_count > 0) lap_count--;
      end
      KIND_DROP_SHORT: begin
        if (lap_count > 0) begin
          for (i = 1; i < lap_count; i++) begin
            lap_times[i-1] = lap_times[i];
            lap_ids[i-1]   = lap_ids[i];
          end
          lap_count--;
        end
      end
      KIND_CLEAR: begin
        lap_count = 0;
      end
      default: ;  // query, and the unused codes behave as query
    endcase

    s = '0;
    s.entry_total = CNT_W'(lap_count);
    if (lap_count > 0) begin
      s.best_ms      = lap_times[0];
      s.best_seconds = SEC_W'(lap_times[0] / MS_PER_SECOND);
      s.best_minutes = MIN_W'(lap_times[0] / MS_PER_MINUTE);
      // First entry in sorted order holding the largest id wins.
      s.top_race     = lap_ids[0];
      s.top_race_ms  = lap_times[0];
      for (i = 1; i < lap_count; i++) begin
        if (lap_ids[i] > s.top_race) begin
          s.top_race    = lap_ids[i];
          s.top_race_ms = lap_times[i];
        end
      end
    end
    if (it.read_index < lap_count) s.indexed_ms = lap_times[it.read_index];
    return s;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, exp_val);
    mismatch_count++;
  endtask

  task automatic queue_item(input logic [KIND_W-1:0] kind, input logic [TIME_W-1:0] lap,
                            input logic [ID_W-1:0] race, input logic auto_num,
                            input logic [RIDX_W-1:0] ridx);
    lap_item_t it;
    it.kind        = kind;
    it.lap_time    = lap;
    it.race_number = race;
    it.auto_number = auto_num;
    it.read_index  = ridx;
    pending_items.push_back(it);
  endtask

  // Random traffic biased toward inserts so the table stays mostly full,
  // with clustered times to hit equal-time ordering and ids near the top
  // of the range to hit auto-number wrap.
  task automatic queue_random(input int unsigned count);
    int unsigned n;
    int unsigned pick;
    logic [KIND_W-1:0] kind;
    logic [TIME_W-1:0] lap;
    logic [ID_W-1:0]   race;
    logic [RIDX_W-1:0] ridx;

    for (n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50)      kind = KIND_INSERT;
      else if (pick < 60) kind = KIND_DROP_LONG;
      else if (pick < 70) kind = KIND_DROP_SHORT;
      else if (pick < 73) kind = KIND_CLEAR;
      else if (pick < 88) kind = KIND_QUERY;
      else                kind = KIND_W'($urandom_range(5, 7));

      pick = $urandom_range(0, 9);
      if (pick < 4)      lap = $urandom;
      else if (pick < 7) lap = $urandom_range(0, 12) * MS_PER_SECOND;
      else if (pick < 9) lap = $urandom_range(0, 200000);
      else               lap = $urandom_range(0, 1) ? '1 : '0;

      pick = $urandom_range(0, 9);
      if (pick < 5)      race = ID_W'($urandom_range(0, 15));
      else if (pick < 8) race = ID_W'($urandom);
      else               race = 16'hFFF0 + ID_W'($urandom_range(0, 15));

      ridx = ($urandom_range(0, 4) == 0) ? RIDX_W'($urandom_range(0, 255))
                                         : RIDX_W'($urandom_range(0, 9));
      queue_item(kind, lap, race, ($urandom_range(0, 2) == 0), ridx);
    end
  endtask

  // Blocks until every item has gone in and every summary has come back.
  // Checked at the rising edge, when the sender's last item already shows
  // on valid and a summary still being taken is still in the queue.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() != 0 || expected_summaries.size() != 0 || item_if.valid);
  endtask

  // Register writes happen only with the block idle; the shadow limit
  // follows once the write edge has passed.
  task automatic set_limit(input logic [CNT_W-1:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    limit_reg = value;
  endtask

  // Sender: bursts of items with random gaps in between. A new item is
  // presented only once the previous one was taken at the last rising edge.
  always @(negedge clk) begin
    if (rst_n && (!item_if.valid || item_taken)) begin
      if (send_gap > 0 || pending_items.size() == 0) begin
        item_if.valid <= 1'b0;
        if (send_gap > 0) send_gap--;
      end else begin
        next_item = pending_items.pop_front();
        item_if.valid       <= 1'b1;
        item_if.kind        <= next_item.kind;
        item_if.lap_time    <= next_item.lap_time;
        item_if.race_number <= next_item.race_number;
        item_if.auto_number <= next_item.auto_number;
        item_if.read_index  <= next_item.read_index;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 15);
          if (send_gaps_on && $urandom_range(0, 3) != 0) send_gap = $urandom_range(1, 80);
        end
      end
    end
  end

  // Receiver: ready drops for stalls of random length, started at random.
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_left > 0) begin
        result_if.ready <= 1'b0;
        stall_left--;
      end else begin
        result_if.ready <= 1'b1;
        if (sink_stalls_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 60);
      end
    end
  end

  // Monitor: checks each summary against the oldest prediction, then logs
  // a prediction for any item taken at the same edge. A summary can never
  // belong to an item taken at the same edge, so this order is safe.
  always @(posedge clk) begin
    if (rst_n) begin
      item_taken   = item_if.valid && item_if.ready;
      result_taken = result_if.valid && result_if.ready;

      if (result_taken) begin
        if (expected_summaries.size() == 0) begin
          report_mismatch("result with nothing outstanding", 32'(result_if.entry_total), 0);
        end else begin
          want = expected_summaries.pop_front();
          if (result_if.entry_total !== want.entry_total)
            report_mismatch("entry_total", 32'(result_if.entry_total),
                            32'(want.entry_total));
          if (result_if.best_ms !== want.best_ms)
            report_mismatch("best_ms", result_if.best_ms, want.best_ms);
          if (result_if.best_seconds !== want.best_seconds)
            report_mismatch("best_seconds", 32'(result_if.best_seconds),
                            32'(want.best_seconds));
          if (result_if.best_minutes !== want.best_minutes)
            report_mismatch("best_minutes", 32'(result_if.best_minutes),
                            32'(want.best_minutes));
          if (result_if.indexed_ms !== want.indexed_ms)
            report_mismatch("indexed_ms", result_if.indexed_ms, want.indexed_ms);
          if (result_if.top_race !== want.top_race)
            report_mismatch("top_race", 32'(result_if.top_race), 32'(want.top_race));
          if (result_if.top_race_ms !== want.top_race_ms)
            report_mismatch("top_race_ms", result_if.top_race_ms, want.top_race_ms);
        end
      end

      if (item_taken) begin
        next_item.kind        = item_if.kind;
        next_item.lap_time    = item_if.lap_time;
        next_item.race_number = item_if.race_number;
        next_item.auto_number = item_if.auto_number;
        next_item.read_index  = item_if.read_index;
        expected_summaries.push_back(update_table(next_item));
      end

      // Watchdog: a hung handshake on either side ends the run.
      if (item_taken || result_taken) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_MAX) begin
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  initial begin
    // Limits walked by the random phases: the extremes 0 and 15, the
    // capacity and one above it, and drops from a full table to small
    // limits so the trim at the next item gets exercised.
    logic [CNT_W-1:0] limits [13];
    int unsigned p;

    limits = '{4'd8, 4'd0, 4'd15, 4'd3, 4'd8, 4'd1, 4'd9,
               4'd2, 4'd8, 4'd6, 4'd4, 4'd7, 4'd15};

    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    item_if.valid       = 1'b0;
    item_if.kind        = '0;
    item_if.lap_time    = '0;
    item_if.race_number = '0;
    item_if.auto_number = 1'b0;
    item_if.read_index  = '0;
    result_if.ready     = 1'b0;
    item_taken          = 1'b0;
    result_taken        = 1'b0;
    idle_cycles         = 0;
    mismatch_count      = 0;
    burst_left          = 0;
    send_gap            = 0;
    stall_left          = 0;
    send_gaps_on        = 1'b1;
    sink_stalls_on      = 1'b1;
    lap_count           = 0;
    limit_reg           = CNT_W'(MAX_ENTRIES_RESET);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed opener at the reset limit of five.
    queue_item(KIND_DROP_LONG,  32'd0,        16'd0,      1'b0, 8'd0);   // drops on empty
    queue_item(KIND_DROP_SHORT, 32'd0,        16'd0,      1'b0, 8'd0);
    queue_item(KIND_INSERT,     32'd5000,     16'd77,     1'b1, 8'd0);   // auto id on empty
    queue_item(KIND_INSERT,     32'hFFFFFFFF, 16'hFFFF,   1'b0, 8'd1);   // field maxima
    queue_item(KIND_INSERT,     32'd60000,    16'd3,      1'b1, 8'd2);   // auto id wraps to 0
    queue_item(KIND_INSERT,     32'd5000,     16'h1234,   1'b0, 8'd1);   // equal time first
    queue_item(KIND_INSERT,     32'd0,        16'd0,      1'b0, 8'd0);   // field minima
    queue_item(KIND_INSERT,     32'd123456789, 16'd7,     1'b0, 8'd5);   // overflow drops longest
    queue_item(KIND_QUERY,      32'd0,        16'd0,      1'b0, 8'd4);
    queue_item(3'd5,            32'd42,       16'd9,      1'b1, 8'd255); // unused kinds query
    queue_item(3'd6,            32'd42,       16'd9,      1'b0, 8'd3);
    queue_item(3'd7,            32'd42,       16'd9,      1'b1, 8'd2);
    queue_item(KIND_DROP_SHORT, 32'd0,        16'd0,      1'b0, 8'd0);
    queue_item(KIND_DROP_LONG,  32'd0,        16'd0,      1'b0, 8'd3);
    queue_item(KIND_CLEAR,      32'd0,        16'd0,      1'b0, 8'd0);
    queue_item(KIND_QUERY,      32'd0,        16'd0,      1'b0, 8'd0);

    // Each phase drains completely before the limit changes, which also
    // holds the sender off until every summary is back.
    for (p = 0; p < 13; p++) begin
      set_limit(limits[p]);
      send_gaps_on   = (p % 3 != 0);
      sink_stalls_on = (p % 4 != 1);
      queue_random(RANDOM_PER_PHASE);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/sbt_pkg.sv
rtl/sbt_in_if.sv
rtl/sbt_out_if.sv
rtl/sbt_div.sv
rtl/sorted_best_times_table_core.sv
tb/sv/sorted_best_times_table_core_tb.sv
